// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// CRC_ASSERT checks a property with the reset disabled.
// CRC_ASSERT_ALWAYS checks a property at every edge, also during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CRC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define CRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CRC_ASSERT(lbl, clk, rstn, prop, msg)
`define CRC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/crc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc_pkg
// Types and constants for the midpoint circle pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package crc_pkg;

	localparam int CRC_COORD_BITS  = 12;
	localparam int CRC_RADIUS_BITS = 10;
	localparam int CRC_QUEUE_DEPTH = 4;

	// pixels emitted by one step word
	localparam int PIXELS_PER_STEP = 8;
	localparam int PIX_IDX_BITS    = $clog2(PIXELS_PER_STEP);

	// symmetric index that gives (cx + x, cy - y): the top pixel when x is 0
	localparam logic [PIX_IDX_BITS-1:0] IDX_TOP  = PIX_IDX_BITS'(2);
	localparam logic [PIX_IDX_BITS-1:0] IDX_LAST = PIX_IDX_BITS'(PIXELS_PER_STEP - 1);

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic STATUS_PIXEL = 1'b0;
	localparam logic STATUS_IDLE  = 1'b1;

	typedef enum logic [1:0] {
		JOB_START,
		JOB_STEP,
		JOB_IDLE
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic      fin;
	} job_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/crc_if.sv =====
// ----------------------------------------------------------------------------
// crc_in_if / crc_out_if
// Valid/ready channels for command words and pixel words.
// ----------------------------------------------------------------------------
`default_nettype none

interface crc_in_if
	import crc_pkg::*;
#(
	parameter int COORD_BITS  = CRC_COORD_BITS,
	parameter int RADIUS_BITS = CRC_RADIUS_BITS
);
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic signed [COORD_BITS-1:0]  center_x;
	logic signed [COORD_BITS-1:0]  center_y;
	logic        [RADIUS_BITS-1:0] radius;

	modport source (output valid, cmd, center_x, center_y, radius, input ready);
	modport sink   (input valid, cmd, center_x, center_y, radius, output ready);
endinterface

interface crc_out_if
	import crc_pkg::*;
#(
	parameter int COORD_BITS = CRC_COORD_BITS
);
	logic                        valid;
	logic                        ready;
	logic signed [COORD_BITS:0]  pixel_x;
	logic signed [COORD_BITS:0]  pixel_y;
	logic                        status;
	logic                        last;
	logic                        finished;

	modport source (output valid, pixel_x, pixel_y, status, last, finished, input ready);
	modport sink   (input valid, pixel_x, pixel_y, status, last, finished, output ready);
endinterface

`default_nettype wire

// ===== hdl/midpoint_circle_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_pixel_generator
// Midpoint circle rasterizer: start and step words in, pixel words out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     word
//  req      in   valid/ready   cmd, center_x, center_y, radius
//  pix      out  valid/ready   pixel_x, pixel_y, status, last, finished
//
// The front takes one command word per cycle while the job queue has room.
// A step word gives eight pixel words, a start or idle step gives one; the
// back end emits one pixel word per cycle while the receiver is ready.
// The queue holds QUEUE_DEPTH jobs, so either side stalls on its own.
// arst_n clears the circle state, the queue, the output valid flag and the pixel count.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_pixel_generator
	import crc_pkg::*;
#(
	parameter int COORD_BITS  = CRC_COORD_BITS,
	parameter int RADIUS_BITS = CRC_RADIUS_BITS,
	parameter int QUEUE_DEPTH = CRC_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	crc_in_if.sink    req,
	crc_out_if.source pix
);

	localparam int OW = RADIUS_BITS + 1;
	localparam int JW = $bits(job_ctl_t) + 2 * COORD_BITS + 2 * OW;

	logic                         push_valid;
	logic                         push_ready;
	job_ctl_t                     f_ctl;
	logic signed [COORD_BITS-1:0] f_cx;
	logic signed [COORD_BITS-1:0] f_cy;
	logic signed [OW-1:0]         f_x;
	logic signed [OW-1:0]         f_y;

	logic                         head_valid;
	logic                         pop;
	logic [JW-1:0]                head_data;
	job_ctl_t                     b_ctl;
	logic signed [COORD_BITS-1:0] b_cx;
	logic signed [COORD_BITS-1:0] b_cy;
	logic signed [OW-1:0]         b_x;
	logic signed [OW-1:0]         b_y;

	crc_front #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.job_ctl    (f_ctl),
		.job_cx     (f_cx),
		.job_cy     (f_cy),
		.job_x      (f_x),
		.job_y      (f_y)
	);

	crc_queue #(
		.WIDTH (JW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({f_ctl, f_cx, f_cy, f_x, f_y}),
		.head_valid (head_valid),
		.pop        (pop),
		.head_data  (head_data)
	);

	assign {b_ctl, b_cx, b_cy, b_x, b_y} = head_data;

	crc_back #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.pop        (pop),
		.job_ctl    (b_ctl),
		.job_cx     (b_cx),
		.job_cy     (b_cy),
		.job_x      (b_x),
		.job_y      (b_y),
		.pix        (pix)
	);

endmodule

`default_nettype wire

// ===== hdl/crc_front.sv =====
// ----------------------------------------------------------------------------
// crc_front
// Accepts command words, keeps the octant point and decision value, and
// pushes one job per word into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module crc_front
	import crc_pkg::*;
#(
	parameter int COORD_BITS  = CRC_COORD_BITS,
	parameter int RADIUS_BITS = CRC_RADIUS_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	crc_in_if.sink                             req,
	output      logic                          push_valid,
	input  wire logic                          push_ready,
	output      job_ctl_t                      job_ctl,
	output      logic signed [COORD_BITS-1:0]  job_cx,
	output      logic signed [COORD_BITS-1:0]  job_cy,
	output      logic signed [RADIUS_BITS:0]   job_x,
	output      logic signed [RADIUS_BITS:0]   job_y
);

	localparam int OW = RADIUS_BITS + 1;
	localparam int DW = RADIUS_BITS + 4;

	logic                         active_q;
	logic signed [OW-1:0]         x_q;
	logic signed [OW-1:0]         y_q;
	logic signed [DW-1:0]         d_q;
	logic signed [COORD_BITS-1:0] cx_q;
	logic signed [COORD_BITS-1:0] cy_q;

	logic                 accept;
	logic signed [DW-1:0] x_ext;
	logic signed [DW-1:0] y_ext;
	logic signed [DW-1:0] d_step;
	logic signed [DW-1:0] d_start;
	logic signed [OW-1:0] x_step;
	logic signed [OW-1:0] y_step;
	logic                 fin_step;

	assign accept     = req.valid && push_ready;
	assign req.ready  = push_ready;
	assign push_valid = req.valid;

	assign x_ext = DW'(x_q);
	assign y_ext = DW'(y_q);

	// midpoint update, wrapped to the decision width
	always_comb begin
		if (d_q[DW-1]) begin
			d_step = d_q + (x_ext <<< 2) + DW'(6);
			y_step = y_q;
		end else begin
			d_step = d_q + ((x_ext - y_ext) <<< 2) + DW'(10);
			y_step = y_q - OW'(1);
		end
		x_step   = x_q + OW'(1);
		fin_step = x_step > y_step;
	end

	assign d_start = DW'(3) - (DW'({1'b0, req.radius}) <<< 1);

	always_comb begin
		job_ctl.fin  = 1'b0;
		job_cx       = cx_q;
		job_cy       = cy_q;
		job_x        = x_q;
		job_y        = y_q;
		case (req.cmd)
			CMD_START: begin
				job_ctl.kind = JOB_START;
				job_cx       = req.center_x;
				job_cy       = req.center_y;
				job_x        = '0;
				job_y        = OW'({1'b0, req.radius});
			end
			CMD_STEP: begin
				if (active_q) begin
					job_ctl.kind = JOB_STEP;
					job_ctl.fin  = fin_step;
				end else begin
					job_ctl.kind = JOB_IDLE;
				end
			end
			default: begin
				job_ctl.kind = JOB_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
		end else if (accept) begin
			if (req.cmd == CMD_START) begin
				active_q <= 1'b1;
				x_q      <= '0;
				y_q      <= OW'({1'b0, req.radius});
				d_q      <= d_start;
				cx_q     <= req.center_x;
				cy_q     <= req.center_y;
			end else if (active_q) begin
				x_q <= x_step;
				y_q <= y_step;
				d_q <= d_step;
				if (fin_step) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	`CRC_ASSERT(a_active_in_octant, clk, arst_n, active_q |-> (x_q <= y_q), "x passed y while active")
	`CRC_ASSERT(a_start_loads, clk, arst_n, (accept && req.cmd == CMD_START) |=> (active_q && x_q == '0), "start did not load the octant point")
	`CRC_ASSERT(a_step_advances, clk, arst_n, (accept && req.cmd == CMD_STEP && active_q) |=> (x_q == $past(x_step)), "step did not advance x")

endmodule

`default_nettype wire

// ===== hdl/crc_queue.sv =====
// ----------------------------------------------------------------------------
// crc_queue
// Small job queue between the command front and the pixel back end.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_queue
	import crc_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = CRC_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output      logic             push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output      logic             head_valid,
	input  wire logic             pop,
	output      logic [WIDTH-1:0] head_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/crc_back.sv =====
// ----------------------------------------------------------------------------
// crc_back
// Expands queued jobs into pixel words, one per cycle while the receiver is
// ready, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module crc_back
	import crc_pkg::*;
#(
	parameter int COORD_BITS  = CRC_COORD_BITS,
	parameter int RADIUS_BITS = CRC_RADIUS_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          head_valid,
	output      logic                          pop,
	input  wire job_ctl_t                      job_ctl,
	input  wire logic signed [COORD_BITS-1:0]  job_cx,
	input  wire logic signed [COORD_BITS-1:0]  job_cy,
	input  wire logic signed [RADIUS_BITS:0]   job_x,
	input  wire logic signed [RADIUS_BITS:0]   job_y,
	crc_out_if.source                          pix
);

	localparam int PW = COORD_BITS + 1;
	localparam int SW = ((COORD_BITS > RADIUS_BITS + 1) ? COORD_BITS : RADIUS_BITS + 1) + 1;

	logic [PIX_IDX_BITS-1:0] cnt_q;
	logic                    ov_q;
	logic signed [PW-1:0]    px_q;
	logic signed [PW-1:0]    py_q;
	logic                    status_q;
	logic                    last_q;
	logic                    fin_q;

	logic                    load;
	logic                    job_done;
	logic [PIX_IDX_BITS-1:0] idx;
	logic signed [SW-1:0]    off_x;
	logic signed [SW-1:0]    off_y;
	logic signed [SW-1:0]    sum_x;
	logic signed [SW-1:0]    sum_y;
	logic signed [PW-1:0]    px_d;
	logic signed [PW-1:0]    py_d;
	logic                    status_d;

	assign load = head_valid && (!ov_q || pix.ready);
	assign pop  = load && job_done;

	always_comb begin
		job_done = 1'b1;
		idx      = IDX_TOP;
		case (job_ctl.kind)
			JOB_STEP: begin
				idx      = cnt_q;
				job_done = cnt_q == IDX_LAST;
			end
			default: begin
				idx      = IDX_TOP;
				job_done = 1'b1;
			end
		endcase
	end

	// idx[2] swaps x and y, idx[0] mirrors the column, idx[1] mirrors the row
	always_comb begin
		off_x = idx[2] ? SW'(job_y) : SW'(job_x);
		off_y = idx[2] ? SW'(job_x) : SW'(job_y);
		sum_x = idx[0] ? SW'(job_cx) - off_x : SW'(job_cx) + off_x;
		sum_y = idx[1] ? SW'(job_cy) - off_y : SW'(job_cy) + off_y;
		if (job_ctl.kind == JOB_IDLE) begin
			px_d     = '0;
			py_d     = '0;
			status_d = STATUS_IDLE;
		end else begin
			px_d     = sum_x[PW-1:0];
			py_d     = sum_y[PW-1:0];
			status_d = STATUS_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q     <= px_d;
			py_q     <= py_d;
			status_q <= status_d;
			last_q   <= job_done;
			fin_q    <= job_ctl.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				cnt_q <= job_done ? '0 : cnt_q + PIX_IDX_BITS'(1);
			end else if (pix.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign pix.valid    = ov_q;
	assign pix.pixel_x  = px_q;
	assign pix.pixel_y  = py_q;
	assign pix.status   = status_q;
	assign pix.last     = last_q;
	assign pix.finished = fin_q;

	`CRC_ASSERT(a_cnt_only_in_step, clk, arst_n, (cnt_q != '0) |-> (head_valid && job_ctl.kind == JOB_STEP), "pixel count set outside a step job")
	`CRC_ASSERT(a_pop_on_last, clk, arst_n, pop |=> (ov_q && last_q), "job dropped before its last pixel")
	`CRC_ASSERT(a_idle_word, clk, arst_n, (load && job_ctl.kind == JOB_IDLE) |=> (status_q == STATUS_IDLE && last_q && !fin_q && px_q == '0 && py_q == '0), "bad idle word")

endmodule

`default_nettype wire

// ===== tb/midpoint_circle_pixel_generator_tb.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_pixel_generator_tb
// Drives start and step words into the circle rasterizer and checks every
// pixel word against an octant walk computed alongside. Directed words cover
// idle steps, zero radius, extreme centers and radii, and restarts. Random
// circles follow, with bursty input, a stalling receiver and drain pauses.
// ----------------------------------------------------------------------------
module midpoint_circle_pixel_generator_tb;
	import crc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIX_W = CRC_COORD_BITS + 1;
	localparam int OCT_W = CRC_RADIUS_BITS + 1;
	localparam int DEC_W = CRC_RADIUS_BITS + 4;
	localparam int WORD_TARGET = 280;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 32;
	localparam int MAX_PRINTED = 50;

	typedef struct {
		logic signed [PIX_W-1:0] px;
		logic signed [PIX_W-1:0] py;
		logic                    status;
		logic                    last;
		logic                    fin;
	} pixel_word_t;

	typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	crc_in_if  req();
	crc_out_if pix();

	midpoint_circle_pixel_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pix    (pix)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// octant walk state, mirrors the block
	logic                           circ_active = 1'b0;
	logic signed [OCT_W-1:0]        oct_x = '0;
	logic signed [OCT_W-1:0]        oct_y = '0;
	logic signed [DEC_W-1:0]        dec_val = '0;
	logic signed [CRC_COORD_BITS-1:0] ctr_x = '0;
	logic signed [CRC_COORD_BITS-1:0] ctr_y = '0;

	pixel_word_t expected_pixels[$];

	int  err_count = 0;
	int  words_sent = 0;
	int  pixels_checked = 0;
	int  circles_done = 0;
	int  idle_replies = 0;
	int  burst_left = 0;
	bit  sender_parked = 1'b1;
	int  idle_cycles = 0;

	task automatic report(input string msg);
		if (err_count < MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic void queue_pixel(input int x, input int y, input logic st,
			input logic lst, input logic fn);
		pixel_word_t w;
		w.px = PIX_W'(x);
		w.py = PIX_W'(y);
		w.status = st;
		w.last = lst;
		w.fin = fn;
		expected_pixels.push_back(w);
	endfunction

	function automatic void rasterize_word(input logic c,
			input logic signed [CRC_COORD_BITS-1:0] cx,
			input logic signed [CRC_COORD_BITS-1:0] cy,
			input logic [CRC_RADIUS_BITS-1:0] r);
		int x, y, cxi, cyi;
		int sx[PIXELS_PER_STEP];
		int sy[PIXELS_PER_STEP];
		logic signed [OCT_W-1:0] nx, ny;
		logic fn;
		if (c == CMD_START) begin
			ctr_x = cx;
			ctr_y = cy;
			oct_x = '0;
			oct_y = OCT_W'(r);
			dec_val = DEC_W'(3 - 2 * int'(r));
			circ_active = 1'b1;
			cxi = ctr_x;
			cyi = ctr_y;
			y = oct_y;
			queue_pixel(cxi, cyi - y, STATUS_PIXEL, 1'b1, 1'b0);
		end else if (!circ_active) begin
			queue_pixel(0, 0, STATUS_IDLE, 1'b1, 1'b0);
		end else begin
			x = oct_x;
			y = oct_y;
			cxi = ctr_x;
			cyi = ctr_y;
			sx = '{cxi + x, cxi - x, cxi + x, cxi - x, cxi + y, cxi - y, cxi + y, cxi - y};
			sy = '{cyi + y, cyi + y, cyi - y, cyi - y, cyi + x, cyi + x, cyi - x, cyi - x};
			if (dec_val < 0) begin
				dec_val = DEC_W'(int'(dec_val) + 4 * x + 6);
			end else begin
				dec_val = DEC_W'(int'(dec_val) + 4 * (x - y) + 10);
				y = y - 1;
			end
			nx = OCT_W'(x + 1);
			ny = OCT_W'(y);
			oct_x = nx;
			oct_y = ny;
			fn = (nx > ny);
			if (fn)
				circ_active = 1'b0;
			for (int k = 0; k < PIXELS_PER_STEP; k++)
				queue_pixel(sx[k], sy[k], STATUS_PIXEL, k == PIXELS_PER_STEP - 1, fn);
		end
	endfunction

	function automatic int next_burst();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 10);
	endfunction

	function automatic logic signed [CRC_COORD_BITS-1:0] rand_coord();
		return CRC_COORD_BITS'($urandom);
	endfunction

	// entered and left at a falling edge
	task automatic send_word(input logic c, input logic signed [CRC_COORD_BITS-1:0] cx,
			input logic signed [CRC_COORD_BITS-1:0] cy,
			input logic [CRC_RADIUS_BITS-1:0] r);
		req.valid <= 1'b1;
		req.cmd <= c;
		req.center_x <= cx;
		req.center_y <= cy;
		req.radius <= r;
		sender_parked = 1'b0;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		rasterize_word(c, cx, cy, r);
		words_sent++;
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			req.valid <= 1'b0;
			sender_parked = 1'b1;
			repeat ($urandom_range(1, 9))
				@(negedge clk);
			burst_left = next_burst();
		end
	endtask

	task automatic send_step();
		send_word(CMD_STEP, rand_coord(), rand_coord(), CRC_RADIUS_BITS'($urandom));
	endtask

	task automatic finish_circle();
		while (circ_active)
			send_step();
	endtask

	// hold the sender until every expected pixel word is out
	task automatic wait_drain();
		if (!sender_parked) begin
			req.valid <= 1'b0;
			sender_parked = 1'b1;
		end
		while (expected_pixels.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_idle_steps();
		send_step();
		send_step();
	endtask

	task automatic test_zero_radius();
		send_word(CMD_START, 12'sd5, -12'sd7, '0);
		send_step();
		send_step();
	endtask

	task automatic test_extremes();
		send_word(CMD_START, -12'sd2048, -12'sd2048, '1);
		repeat (3) send_step();
		// restart while a circle is still open
		send_word(CMD_START, 12'sd2047, 12'sd2047, '1);
		repeat (3) send_step();
		send_word(CMD_START, 12'sd2047, -12'sd2048, 10'd1);
		finish_circle();
		send_step();
		send_word(CMD_START, -12'sd2048, 12'sd2047, 10'd2);
		finish_circle();
	endtask

	task automatic test_drain_pause();
		send_word(CMD_START, rand_coord(), rand_coord(), 10'd3);
		send_step();
		wait_drain();
		finish_circle();
		wait_drain();
	endtask

	task automatic test_random_circles();
		int limit, steps, circles;
		logic [CRC_RADIUS_BITS-1:0] r;
		circles = 0;
		while (words_sent < WORD_TARGET) begin
			if ($urandom_range(0, 99) < 12) begin
				send_word(CMD_START ^ logic'($urandom_range(0, 1)), rand_coord(),
					rand_coord(), CRC_RADIUS_BITS'($urandom));
			end else begin
				case ($urandom_range(0, 19))
					0:       r = CRC_RADIUS_BITS'($urandom);
					1, 2:    r = CRC_RADIUS_BITS'($urandom_range(25, 120));
					default: r = CRC_RADIUS_BITS'($urandom_range(0, 24));
				endcase
				send_word(CMD_START, rand_coord(), rand_coord(), r);
				limit = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 100;
				steps = 0;
				while (circ_active && steps < limit) begin
					send_step();
					steps++;
				end
				if (!circ_active)
					repeat ($urandom_range(0, 2)) send_step();
				circles++;
				if (circles % 7 == 0)
					wait_drain();
			end
		end
	endtask

	// receiver stall pattern
	rx_mode_t rx_mode = RX_FREE;
	int       rx_left = 0;
	int       rx_hold = 0;
	bit       rx_gate = 1'b1;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 96);
		end
		rx_left--;
		case (rx_mode)
			RX_FREE: begin
				pix.ready <= 1'b1;
			end
			RX_RANDOM: begin
				pix.ready <= ($urandom_range(0, 3) != 0);
			end
			RX_PERIODIC: begin
				pix.ready <= (rx_left % 3 != 0);
			end
			default: begin
				if (rx_hold == 0) begin
					rx_gate = !rx_gate;
					rx_hold = rx_gate ? $urandom_range(1, 8) : $urandom_range(1, 16);
				end
				rx_hold--;
				pix.ready <= rx_gate;
			end
		endcase
	end

	always @(posedge clk) begin : check_pixels
		pixel_word_t want;
		if (arst_n && pix.valid && pix.ready) begin
			if (expected_pixels.size() == 0) begin
				report($sformatf("unexpected word x=%0d y=%0d status=%0b",
					pix.pixel_x, pix.pixel_y, pix.status));
			end else begin
				want = expected_pixels.pop_front();
				if (pix.pixel_x !== want.px)
					report($sformatf("pixel_x got %0d want %0d", pix.pixel_x, want.px));
				if (pix.pixel_y !== want.py)
					report($sformatf("pixel_y got %0d want %0d", pix.pixel_y, want.py));
				if (pix.status !== want.status)
					report($sformatf("status got %b want %b", pix.status, want.status));
				if (pix.last !== want.last)
					report($sformatf("last got %b want %b", pix.last, want.last));
				if (pix.finished !== want.fin)
					report($sformatf("finished got %b want %b", pix.finished, want.fin));
				pixels_checked++;
				if (want.status == STATUS_IDLE)
					idle_replies++;
				if (want.fin && want.last)
					circles_done++;
			end
		end
	end

	// give up when neither side has moved a word for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (pix.valid && pix.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] timeout: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
				$display("midpoint_circle_pixel_generator_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_START;
		req.center_x = '0;
		req.center_y = '0;
		req.radius = '0;
		pix.ready = 1'b0;
		burst_left = next_burst();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_steps();
		test_zero_radius();
		test_extremes();
		test_drain_pause();
		test_random_circles();

		wait_drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d command words and %0d pixel words: %0d circles completed,",
			words_sent, pixels_checked, circles_done);
		$display("%0d idle replies, %0d mismatches", idle_replies, err_count);
		if (err_count == 0)
			$display("midpoint_circle_pixel_generator_tb: done, clean");
		else
			$display("midpoint_circle_pixel_generator_tb: done, errors");
		$finish;
	end

endmodule
